@@ hdl/dwmc_pkg.sv @@
// Shared constants and register codes for the DNA wildcard motif counter.
// No dependencies; every other file of the block refers to this package.
package dwmc_pkg;

	localparam int MAX_MOTIFS    = 8;
	localparam int MAX_MOTIF_LEN = 8;

	localparam int BASE_W     = 3;
	localparam int SYM_W      = 4;
	localparam int LEN_W      = 4;
	localparam int POS_W      = 32;
	localparam int SEQ_W      = 16;
	localparam int TOTAL_W    = 32;
	localparam int MOTIF_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [SYM_W-1:0] WILDCARD = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIR_0 = 3'd0,
		REG_PAIR_1 = 3'd1,
		REG_PAIR_2 = 3'd2,
		REG_PAIR_3 = 3'd3,
		REG_LENGTH = 3'd4,
		REG_COUNT  = 3'd5
	} cfg_reg_t;

endpackage

@@ hdl/dwmc_if.sv @@
// Valid/ready channel interfaces: base words in, result words out, register writes.
// Depends on dwmc_pkg for field widths.
interface dwmc_base_if;
	logic                          valid;
	logic                          ready;
	logic [dwmc_pkg::BASE_W-1:0]   base;
	logic                          sequence_end;

	modport source (output valid, base, sequence_end, input ready);
	modport sink   (input valid, base, sequence_end, output ready);
endinterface

interface dwmc_result_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [dwmc_pkg::POS_W-1:0]    hit_start;
	logic [dwmc_pkg::SEQ_W-1:0]    sequence_number;
	logic [dwmc_pkg::TOTAL_W-1:0]  hit_total;

	modport source (output valid, hit, hit_start, sequence_number, hit_total, input ready);
	modport sink   (input valid, hit, hit_start, sequence_number, hit_total, output ready);
endinterface

interface dwmc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dwmc_pkg::CFG_IDX_W-1:0]   index;
	logic [dwmc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/dna_wildcard_motif_counter_top.sv @@
// Top level of the DNA wildcard motif counter: window, motif compare, counters.
// Depends on dwmc_pkg and the channel interfaces in dwmc_if.sv.
//
//   channel   dir   word                                              handshake
//   bases     in    base, sequence_end                                valid/ready
//   results   out   hit, hit_start, sequence_number, hit_total        valid/ready
//   cfg       in    index, data                                       valid/ready
//
// One base word per cycle while results is not stalled; a taken base is held in the input
// register and passes to the result register when that is empty or being read. The motif
// compare is one pass of parallel symbol compares between those two registers.
// Reset (arst_n low) clears valid flags, motifs, motif count, window and counters and
// sets motif length to one, at once. A stalled results channel holds its word; bases
// keeps flowing until both stages are full. cfg is always ready.
module dna_wildcard_motif_counter_top #(
	parameter int MAX_MOTIFS    = dwmc_pkg::MAX_MOTIFS,
	parameter int MAX_MOTIF_LEN = dwmc_pkg::MAX_MOTIF_LEN
) (
	input  logic          clk,
	input  logic          arst_n,
	dwmc_base_if.sink     bases,
	dwmc_result_if.source results,
	dwmc_cfg_if.sink      cfg
);

	localparam int NumPairs = (MAX_MOTIFS + 1) / 2;
	localparam int FillW    = $clog2(MAX_MOTIF_LEN + 1);

	localparam int BW = dwmc_pkg::BASE_W;
	localparam int SW = dwmc_pkg::SYM_W;
	localparam int LW = dwmc_pkg::LEN_W;

	// configuration
	logic [LW-1:0]                   motif_length_q;
	logic [LW-1:0]                   motif_count_q;
	logic [dwmc_pkg::CFG_DATA_W-1:0] pair_q [NumPairs];

	// input stage
	logic          v_s1;
	logic [BW-1:0] base_s1;
	logic          end_s1;

	// stream state
	logic [BW-1:0]                window_q [MAX_MOTIF_LEN];
	logic [FillW-1:0]             fill_q;
	logic [dwmc_pkg::POS_W-1:0]   pos_q;
	logic [dwmc_pkg::SEQ_W-1:0]   seq_q;
	logic [dwmc_pkg::TOTAL_W-1:0] total_q;

	// result stage
	logic                         v_s2;
	logic                         hit_s2;
	logic [dwmc_pkg::POS_W-1:0]   hit_start_s2;
	logic [dwmc_pkg::SEQ_W-1:0]   seq_s2;
	logic [dwmc_pkg::TOTAL_W-1:0] total_s2;

	// combinational
	logic                         take_in;
	logic                         adv_s1;
	logic [LW-1:0]                len_eff;
	logic [LW-1:0]                cnt_eff;
	logic [BW-1:0]                win_nxt [MAX_MOTIF_LEN];
	logic [FillW-1:0]             fill_nxt;
	logic [SW-1:0]                sym;
	logic [BW-1:0]                cur;
	logic                         motif_ok;
	logic                         hit_any;
	logic                         hit;
	logic [dwmc_pkg::POS_W-1:0]   hit_start;
	logic [dwmc_pkg::TOTAL_W-1:0] total_nxt;

	assign adv_s1      = v_s1 && (!v_s2 || results.ready);
	assign bases.ready = !v_s1 || adv_s1;
	assign take_in     = bases.valid && bases.ready;
	assign cfg.ready   = 1'b1;

	assign results.valid           = v_s2;
	assign results.hit             = hit_s2;
	assign results.hit_start       = hit_start_s2;
	assign results.sequence_number = seq_s2;
	assign results.hit_total       = total_s2;

	always_comb begin
		if (motif_length_q == '0) begin
			len_eff = LW'(1);
		end else if (motif_length_q > LW'(MAX_MOTIF_LEN)) begin
			len_eff = LW'(MAX_MOTIF_LEN);
		end else begin
			len_eff = motif_length_q;
		end
		if (motif_count_q > LW'(MAX_MOTIFS)) begin
			cnt_eff = LW'(MAX_MOTIFS);
		end else begin
			cnt_eff = motif_count_q;
		end
	end

	always_comb begin
		win_nxt[0] = base_s1;
		for (int i = 1; i < MAX_MOTIF_LEN; i++) begin
			win_nxt[i] = window_q[i-1];
		end
		fill_nxt = (fill_q < FillW'(MAX_MOTIF_LEN)) ? fill_q + FillW'(1) : fill_q;
	end

	// symbol n of a motif lines up with the base of age len-1-n
	always_comb begin
		hit_any  = 1'b0;
		motif_ok = 1'b1;
		sym      = '0;
		cur      = '0;
		for (int k = 0; k < MAX_MOTIFS; k++) begin
			motif_ok = 1'b1;
			for (int n = 0; n < MAX_MOTIF_LEN; n++) begin
				sym = pair_q[k >> 1][dwmc_pkg::MOTIF_W * (k & 1) + SW * n +: SW];
				cur = '0;
				for (int a = 0; a < MAX_MOTIF_LEN; a++) begin
					if (LW'(a + n + 1) == len_eff) begin
						cur = win_nxt[a];
					end
				end
				if (LW'(n) < len_eff && sym != dwmc_pkg::WILDCARD
						&& sym != {1'b0, cur}) begin
					motif_ok = 1'b0;
				end
			end
			if (LW'(k) < cnt_eff && motif_ok) begin
				hit_any = 1'b1;
			end
		end
		hit       = hit_any && (LW'(fill_nxt) >= len_eff);
		hit_start = hit ? pos_q - dwmc_pkg::POS_W'(len_eff) + dwmc_pkg::POS_W'(1) : '0;
		total_nxt = (hit && total_q != '1) ? total_q + dwmc_pkg::TOTAL_W'(1) : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_length_q <= LW'(1);
			motif_count_q  <= '0;
			for (int p = 0; p < NumPairs; p++) begin
				pair_q[p] <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				dwmc_pkg::REG_LENGTH: motif_length_q <= cfg.data[LW-1:0];
				dwmc_pkg::REG_COUNT:  motif_count_q  <= cfg.data[LW-1:0];
				default: begin
					for (int p = 0; p < NumPairs; p++) begin
						if (cfg.index == dwmc_pkg::CFG_IDX_W'(p)) begin
							pair_q[p] <= cfg.data;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			fill_q  <= '0;
			pos_q   <= '0;
			seq_q   <= '0;
			total_q <= '0;
			for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
				window_q[i] <= '0;
			end
		end else begin
			if (take_in) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (results.ready) begin
				v_s2 <= 1'b0;
			end
			if (adv_s1) begin
				for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
					window_q[i] <= win_nxt[i];
				end
				total_q <= total_nxt;
				if (end_s1) begin
					fill_q <= '0;
					pos_q  <= '0;
					seq_q  <= seq_q + dwmc_pkg::SEQ_W'(1);
				end else begin
					fill_q <= fill_nxt;
					pos_q  <= pos_q + dwmc_pkg::POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			base_s1 <= bases.base;
			end_s1  <= bases.sequence_end;
		end
		if (adv_s1) begin
			hit_s2       <= hit;
			hit_start_s2 <= hit_start;
			seq_s2       <= seq_q;
			total_s2     <= total_nxt;
		end
	end

	a_end_clears_pos : assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && end_s1 |=> pos_q == '0 && fill_q == '0)
		else $error("position not cleared after sequence end");

	a_total_monotonic : assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> total_q >= $past(total_q))
		else $error("hit total decreased");

	a_hit_has_total : assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && hit |=> v_s2 && hit_s2 && total_s2 != '0)
		else $error("hit delivered with zero total");

	a_no_hit_zero_start : assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !hit |=> hit_start_s2 == '0)
		else $error("hit_start nonzero without a hit");

endmodule

@@ verif/dna_wildcard_motif_counter_checker.sv @@
`timescale 1ns / 100ps
// Checker for the DNA wildcard motif counter. It watches the base, result and register
// channels, predicts each result word and compares it field by field with the output.
// Depends on dwmc_pkg and the channel interfaces in dwmc_if.sv.
module dna_wildcard_motif_counter_checker (
	input  logic   clk,
	input  logic   arst_n,
	dwmc_base_if   bases,
	dwmc_result_if results,
	dwmc_cfg_if    cfg,
	output int     failures,
	output int     outstanding
);

	typedef struct packed {
		logic                         hit;
		logic [dwmc_pkg::POS_W-1:0]   hit_start;
		logic [dwmc_pkg::SEQ_W-1:0]   sequence_number;
		logic [dwmc_pkg::TOTAL_W-1:0] hit_total;
	} motif_result_t;

	logic [dwmc_pkg::CFG_DATA_W-1:0] motif_pairs [4] = '{default: '0};
	logic [dwmc_pkg::LEN_W-1:0]      length_reg = 4'd1;
	logic [dwmc_pkg::LEN_W-1:0]      count_reg = '0;

	logic [dwmc_pkg::BASE_W-1:0]     recent_bases [dwmc_pkg::MAX_MOTIF_LEN] = '{default: '0};
	int unsigned                     bases_held = 0;
	logic [dwmc_pkg::POS_W-1:0]      next_position = '0;
	logic [dwmc_pkg::SEQ_W-1:0]      seq_index = '0;
	logic [dwmc_pkg::TOTAL_W-1:0]    hits_so_far = '0;

	motif_result_t                   predicted_results [$];

	function automatic logic window_matches(logic [dwmc_pkg::MOTIF_W-1:0] motif,
		int unsigned len);
		logic [dwmc_pkg::SYM_W-1:0] sym;
		for (int n = 0; n < len; n++) begin
			sym = motif[dwmc_pkg::SYM_W*n +: dwmc_pkg::SYM_W];
			if (sym != dwmc_pkg::WILDCARD && sym != {1'b0, recent_bases[len-1-n]})
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic motif_result_t scan_base(logic [dwmc_pkg::BASE_W-1:0] b, logic last);
		motif_result_t                r;
		int unsigned                  len;
		int unsigned                  cnt;
		logic [dwmc_pkg::MOTIF_W-1:0] motif;
		logic                         found;
		len = length_reg;
		if (len == 0)
			len = 1;
		if (len > dwmc_pkg::MAX_MOTIF_LEN)
			len = dwmc_pkg::MAX_MOTIF_LEN;
		cnt = count_reg;
		if (cnt > dwmc_pkg::MAX_MOTIFS)
			cnt = dwmc_pkg::MAX_MOTIFS;
		for (int i = dwmc_pkg::MAX_MOTIF_LEN - 1; i > 0; i--)
			recent_bases[i] = recent_bases[i-1];
		recent_bases[0] = b;
		if (bases_held < dwmc_pkg::MAX_MOTIF_LEN)
			bases_held++;
		found = 1'b0;
		if (bases_held >= len) begin
			for (int k = 0; k < cnt; k++) begin
				motif = motif_pairs[k/2][dwmc_pkg::MOTIF_W*(k%2) +: dwmc_pkg::MOTIF_W];
				if (window_matches(motif, len))
					found = 1'b1;
			end
		end
		if (found && hits_so_far != '1)
			hits_so_far++;
		r.hit             = found;
		r.hit_start       = found ? next_position - dwmc_pkg::POS_W'(len - 1) : '0;
		r.sequence_number = seq_index;
		r.hit_total       = hits_so_far;
		if (last) begin
			bases_held    = 0;
			next_position = '0;
			seq_index++;
		end else begin
			next_position++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		motif_result_t want;
		if (!arst_n) begin
			motif_pairs   = '{default: '0};
			length_reg    = 4'd1;
			count_reg     = '0;
			recent_bases  = '{default: '0};
			bases_held    = 0;
			next_position = '0;
			seq_index     = '0;
			hits_so_far   = '0;
			predicted_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					dwmc_pkg::REG_PAIR_0, dwmc_pkg::REG_PAIR_1,
					dwmc_pkg::REG_PAIR_2, dwmc_pkg::REG_PAIR_3: begin
						motif_pairs[cfg.index[1:0]] = cfg.data;
					end
					dwmc_pkg::REG_LENGTH: begin
						length_reg = cfg.data[dwmc_pkg::LEN_W-1:0];
					end
					dwmc_pkg::REG_COUNT: begin
						count_reg = cfg.data[dwmc_pkg::LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (bases.valid && bases.ready)
				predicted_results.push_back(scan_base(bases.base, bases.sequence_end));
			if (results.valid && results.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result word with no prediction waiting");
					failures++;
				end else begin
					want = predicted_results.pop_front();
					if (results.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, results.hit);
						failures++;
					end
					if (results.hit_start !== want.hit_start) begin
						$error("hit_start: expected %0d, got %0d", want.hit_start,
							results.hit_start);
						failures++;
					end
					if (results.sequence_number !== want.sequence_number) begin
						$error("sequence_number: expected %0d, got %0d",
							want.sequence_number, results.sequence_number);
						failures++;
					end
					if (results.hit_total !== want.hit_total) begin
						$error("hit_total: expected %0d, got %0d", want.hit_total,
							results.hit_total);
						failures++;
					end
				end
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

@@ verif/dna_wildcard_motif_counter_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the DNA wildcard motif counter: clock, reset, base and register
// stimulus, result back-pressure and the verdict. Depends on dwmc_pkg, dwmc_if.sv and
// dna_wildcard_motif_counter_checker.
module dna_wildcard_motif_counter_top_test;

	localparam logic [dwmc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
	localparam logic [dwmc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_BASES   = 103;

	logic clk = 1'b0;
	logic arst_n;
	int   failures;
	int   outstanding;

	logic [dwmc_pkg::CFG_DATA_W-1:0] pair_words [4];
	logic [dwmc_pkg::LEN_W-1:0]      length_word;
	logic [dwmc_pkg::LEN_W-1:0]      count_word;
	int unsigned                     shown_length;
	int unsigned                     slots_used;

	dwmc_base_if   bases ();
	dwmc_result_if results ();
	dwmc_cfg_if    cfg ();

	dna_wildcard_motif_counter_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bases   (bases),
		.results (results),
		.cfg     (cfg)
	);

	dna_wildcard_motif_counter_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.bases       (bases),
		.results     (results),
		.cfg         (cfg),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	function automatic logic [dwmc_pkg::BASE_W-1:0] random_base();
		if ($urandom_range(0, 4) == 0)
			return dwmc_pkg::BASE_W'($urandom_range(4, 7));
		return dwmc_pkg::BASE_W'($urandom_range(0, 3));
	endfunction

	function automatic logic [dwmc_pkg::MOTIF_W-1:0] random_motif();
		logic [dwmc_pkg::MOTIF_W-1:0] motif;
		int unsigned                  r;
		for (int n = 0; n < dwmc_pkg::MAX_MOTIF_LEN; n++) begin
			r = $urandom_range(0, 19);
			if (r < 12)
				motif[dwmc_pkg::SYM_W*n +: dwmc_pkg::SYM_W] = dwmc_pkg::SYM_W'(r % 4);
			else if (r < 16)
				motif[dwmc_pkg::SYM_W*n +: dwmc_pkg::SYM_W] = dwmc_pkg::WILDCARD;
			else
				motif[dwmc_pkg::SYM_W*n +: dwmc_pkg::SYM_W] =
					dwmc_pkg::SYM_W'($urandom_range(4, 15));
		end
		return motif;
	endfunction

	task automatic send_base(input logic [dwmc_pkg::BASE_W-1:0] b, input logic last);
		int unsigned gap;
		gap = $urandom_range(0, 5);
		if (gap != 0) begin
			bases.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bases.valid        <= 1'b1;
		bases.base         <= b;
		bases.sequence_end <= last;
		do @(posedge clk); while (!bases.ready);
	endtask

	task automatic write_reg(input logic [dwmc_pkg::CFG_IDX_W-1:0] idx,
		input logic [dwmc_pkg::CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// drain the pipeline, then load every register from the mirror and write random data to one unmapped index
	task automatic program_motifs();
		bases.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		write_reg(dwmc_pkg::REG_PAIR_0, pair_words[0]);
		write_reg(dwmc_pkg::REG_PAIR_1, pair_words[1]);
		write_reg(dwmc_pkg::REG_PAIR_2, pair_words[2]);
		write_reg(dwmc_pkg::REG_PAIR_3, pair_words[3]);
		write_reg(dwmc_pkg::REG_LENGTH, {$urandom, 28'($urandom), length_word});
		write_reg(dwmc_pkg::REG_COUNT, {$urandom, 28'($urandom), count_word});
		write_reg($urandom_range(0, 1) ? REG_UNMAPPED_6 : REG_UNMAPPED_7,
			{$urandom, $urandom});
		cfg.valid <= 1'b0;
		shown_length = (length_word == 0) ? 1 :
			(length_word > dwmc_pkg::MAX_MOTIF_LEN) ? dwmc_pkg::MAX_MOTIF_LEN : length_word;
		slots_used = (count_word > dwmc_pkg::MAX_MOTIFS) ? dwmc_pkg::MAX_MOTIFS : count_word;
	endtask

	task automatic send_motif_instance();
		int unsigned                  slot;
		logic [dwmc_pkg::MOTIF_W-1:0] motif;
		logic [dwmc_pkg::SYM_W-1:0]   sym;
		slot  = $urandom_range(0, slots_used - 1);
		motif = pair_words[slot/2][dwmc_pkg::MOTIF_W*(slot%2) +: dwmc_pkg::MOTIF_W];
		for (int n = 0; n < shown_length; n++) begin
			sym = motif[dwmc_pkg::SYM_W*n +: dwmc_pkg::SYM_W];
			send_base(sym < dwmc_pkg::WILDCARD ? sym[dwmc_pkg::BASE_W-1:0] : random_base(),
				n == shown_length - 1 && $urandom_range(0, 15) == 0);
		end
	endtask

	// back-pressure on the result channel
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 5);
			if (stall != 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
		end
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int unsigned sent;
		arst_n             = 1'b0;
		bases.valid        = 1'b0;
		bases.base         = '0;
		bases.sequence_end = 1'b0;
		cfg.valid          = 1'b0;
		cfg.index          = '0;
		cfg.data           = '0;
		results.ready      = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: no motifs in use, every base code once
		for (int b = 0; b < 8; b++)
			send_base(dwmc_pkg::BASE_W'(b), b == 7);

		// exact motif, wildcard motif, high codes, never-matching symbols
		pair_words  = '{{32'h0000_3810, 32'h0000_3210}, {32'hFFFF_FFFF, 32'h0000_7654},
			'0, '0};
		length_word = 4'd4;
		count_word  = 4'd4;
		program_motifs();
		send_base(3'd0, 1'b0);
		send_base(3'd1, 1'b0);
		send_base(3'd2, 1'b0);
		send_base(3'd3, 1'b0);
		send_base(3'd0, 1'b0);
		send_base(3'd1, 1'b0);
		send_base(3'd0, 1'b0);
		send_base(3'd3, 1'b1);
		send_base(3'd2, 1'b0);
		send_base(3'd3, 1'b0);

		// length zero acts as one, count above the slot total
		pair_words[2] = {32'hFFFF_FFFF, 32'h8888_8888};
		length_word   = 4'd0;
		count_word    = 4'hF;
		program_motifs();
		send_base(3'd5, 1'b0);
		send_base(3'd6, 1'b1);

		// length above the window size
		pair_words[3] = {32'h8888_8888, 32'h8888_8888};
		length_word   = 4'hF;
		program_motifs();
		for (int i = 0; i < 8; i++)
			send_base(random_base(), i == 7);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					pair_words  = '{default: '1};
					length_word = 4'hF;
					count_word  = 4'hF;
				end
				1: begin
					pair_words  = '{default: '0};
					length_word = 4'd8;
					count_word  = 4'd8;
				end
				default: begin
					for (int p = 0; p < 4; p++)
						pair_words[p] = {random_motif(), random_motif()};
					if ($urandom_range(0, 9) == 0)
						length_word = $urandom_range(0, 1) ? 4'd0 :
							dwmc_pkg::LEN_W'($urandom_range(9, 15));
					else
						length_word = (phase == 2) ? 4'd1 :
							dwmc_pkg::LEN_W'($urandom_range(1, 8));
					count_word = ($urandom_range(0, 9) == 0) ?
						dwmc_pkg::LEN_W'($urandom_range(9, 15)) :
						dwmc_pkg::LEN_W'($urandom_range(0, 8));
				end
			endcase
			program_motifs();
			sent = 0;
			while (sent < PHASE_BASES) begin
				if (slots_used != 0 && $urandom_range(0, 1) == 1) begin
					send_motif_instance();
					sent += shown_length;
				end else begin
					send_base(random_base(), $urandom_range(0, 15) == 0);
					sent++;
				end
			end
		end

		bases.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ dna_wildcard_motif_counter_top.f @@
hdl/dwmc_pkg.sv
hdl/dwmc_if.sv
hdl/dna_wildcard_motif_counter_top.sv
verif/dna_wildcard_motif_counter_checker.sv
verif/dna_wildcard_motif_counter_top_test.sv
